/* rtl/window_min_max_mean_monitor_unit_assert.svh */
// Assertion macros shared by the monitor RTL.
`ifndef WINDOW_MIN_MAX_MEAN_MONITOR_UNIT_ASSERT_SVH
`define WINDOW_MIN_MAX_MEAN_MONITOR_UNIT_ASSERT_SVH
`ifndef ASSERT_OFF
`define WMM_ASSERT_ALWAYS(label, clk, rst, cond) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("wmm: invariant violated");
`define WMM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("wmm: sequence violated");
`else
`define WMM_ASSERT_ALWAYS(label, clk, rst, cond)
`define WMM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/wmm_pkg.sv */
`timescale 1ns / 1ps
package wmm_pkg;

   localparam int WINDOW_DEFAULT      = 100;
   localparam int SAMPLE_BITS_DEFAULT = 16;
   localparam int STATE_BITS_DEFAULT  = 8;
   localparam int FILL_BITS           = 7;
   localparam int CSR_INDEX_BITS      = 8;
   localparam int LOW_SEED_RESET      = 25600;
   localparam int HIGH_SEED_RESET     = 0;

   localparam logic [CSR_INDEX_BITS-1:0] REG_TEMP_LOW_SEED   = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] REG_TEMP_HIGH_SEED  = 8'd1;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PRESS_LOW_SEED  = 8'd2;
   localparam logic [CSR_INDEX_BITS-1:0] REG_PRESS_HIGH_SEED = 8'd3;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_SCAN  = 5'b00010,
      ST_START = 5'b00100,
      ST_DIV   = 5'b01000,
      ST_LOAD  = 5'b10000
   } fsm_state_type;

endpackage

/* rtl/wmm_ring.sv */
`timescale 1ns / 1ps
// Reading store: one write port, one read port, registered read data.
module wmm_ring #(
   parameter int DEPTH = 100,
   parameter int EW    = 41,
   parameter int AW    = 7
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [EW-1:0] wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [EW-1:0] rd_data
);
   logic [EW-1:0] mem [DEPTH];
   logic [EW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* rtl/wmm_div.sv */
`timescale 1ns / 1ps
// Restoring unsigned divider, one quotient bit per cycle.
module wmm_div #(
   parameter int DW = 32
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [DW-1:0] dividend,
   input  logic [DW-1:0] divisor,
   output logic          busy,
   output logic [DW-1:0] quotient
);
   localparam int CNTW = $clog2(DW + 1);

   logic [DW-1:0]   rem_ff, rem_in, quo_ff, quo_in, dvs_ff;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            busy_ff, busy_in;
   logic [DW:0]     trial, diff;
   logic            ge;

   always_comb begin
      trial   = {rem_ff, quo_ff[DW-1]};
      diff    = trial - {1'b0, dvs_ff};
      ge      = (trial >= {1'b0, dvs_ff});
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         cnt_in  = CNTW'(DW);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = ge ? diff[DW-1:0] : trial[DW-1:0];
         quo_in = {quo_ff[DW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (start) begin
         dvs_ff <= divisor;
      end
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;
endmodule

/* rtl/window_min_max_mean_monitor_unit.sv */
`timescale 1ns / 1ps
// Channel   Direction  Transfer when          Carries
// req_      in         req_valid & req_ready  one sensor reading
// rsp_      out        rsp_valid & rsp_ready  window extremes, means, flag, fill
// csr_      in         csr_valid & csr_ready  seed register index and value
//
// A reading is stored, then the held entries of the ring are scanned through
// its single read port, then the three dividers are started and divide, and
// last the output register is loaded.
// Reset clears control state, the fill count and the write slot, and sets the seeds to their reset values.
// A new reading is taken only when the block is idle; a result held in the
// output register does not stop that, and the next result waits for it.
`include "window_min_max_mean_monitor_unit_assert.svh"
module window_min_max_mean_monitor_unit #(
   parameter int WINDOW      = wmm_pkg::WINDOW_DEFAULT,
   parameter int SAMPLE_BITS = wmm_pkg::SAMPLE_BITS_DEFAULT,
   parameter int STATE_BITS  = wmm_pkg::STATE_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic signed [SAMPLE_BITS-1:0]      req_temperature,
   input  logic signed [SAMPLE_BITS-1:0]      req_pressure,
   input  logic [STATE_BITS-1:0]              req_pod_state,
   input  logic                               req_water_seen,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]      rsp_highest_temp,
   output logic signed [SAMPLE_BITS-1:0]      rsp_lowest_temp,
   output logic signed [SAMPLE_BITS-1:0]      rsp_mean_temp,
   output logic signed [SAMPLE_BITS-1:0]      rsp_highest_press,
   output logic signed [SAMPLE_BITS-1:0]      rsp_lowest_press,
   output logic signed [SAMPLE_BITS-1:0]      rsp_mean_press,
   output logic [STATE_BITS-1:0]              rsp_mean_state,
   output logic                               rsp_water_status,
   output logic [wmm_pkg::FILL_BITS-1:0]      rsp_fill_count,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [wmm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [SAMPLE_BITS-1:0]             csr_wdata
);
   import wmm_pkg::*;

   localparam int SB  = SAMPLE_BITS;
   localparam int STB = STATE_BITS;
   localparam int IW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int CW  = $clog2(WINDOW + 1);
   localparam int EW  = 2 * SB + STB + 1;
   localparam int AW  = SB + CW;          // signed sample sum
   localparam int SW  = STB + CW;         // unsigned state sum
   localparam int DW  = ((SB > STB + 1) ? SB : STB + 1) + CW + 1;

   fsm_state_type state_ff, state_in;

   // Seed registers.
   logic signed [SB-1:0] t_lo_seed_ff, t_hi_seed_ff, p_lo_seed_ff, p_hi_seed_ff;

   // Ring pointers.
   logic [IW-1:0] wslot_ff, wslot_in, issue_ff, issue_in;
   logic [CW-1:0] held_ff, held_in;
   logic          issuing_ff, issuing_in, rd_vld_ff, rd_last_ff, last_issue;

   // Scan accumulators.
   logic signed [SB-1:0] t_hi_ff, t_hi_in, t_lo_ff, t_lo_in;
   logic signed [SB-1:0] p_hi_ff, p_hi_in, p_lo_ff, p_lo_in;
   logic signed [AW-1:0] t_sum_ff, t_sum_in, p_sum_ff, p_sum_in;
   logic [SW-1:0]        s_sum_ff, s_sum_in;
   logic                 water_ff;

   logic [EW-1:0]        rd_data;
   logic signed [SB-1:0] rd_temp, rd_press;
   logic [STB-1:0]       rd_state;

   logic                 accept, div_start, t_busy, p_busy, s_busy;
   logic [AW-1:0]        t_mag, p_mag;
   logic [DW-1:0]        t_quo, p_quo, s_quo, s_dividend;
   logic [SB-1:0]        t_mean, p_mean;
   logic                 rsp_valid_ff, out_free;

   assign accept    = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         t_lo_seed_ff <= SB'(LOW_SEED_RESET);
         t_hi_seed_ff <= SB'(HIGH_SEED_RESET);
         p_lo_seed_ff <= SB'(LOW_SEED_RESET);
         p_hi_seed_ff <= SB'(HIGH_SEED_RESET);
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_TEMP_LOW_SEED:   t_lo_seed_ff <= csr_wdata;
            REG_TEMP_HIGH_SEED:  t_hi_seed_ff <= csr_wdata;
            REG_PRESS_LOW_SEED:  p_lo_seed_ff <= csr_wdata;
            REG_PRESS_HIGH_SEED: p_hi_seed_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // The new reading goes into the ring on the accepting edge, so the scan
   // that follows sees it without any forwarding.
   wmm_ring #(.DEPTH(WINDOW), .EW(EW), .AW(IW)) u_ring (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (wslot_ff),
      .wr_data ({req_temperature, req_pressure, req_pod_state, req_water_seen}),
      .rd_en   (issuing_ff),
      .rd_addr (issue_ff),
      .rd_data (rd_data)
   );

   assign rd_temp    = rd_data[EW-1 -: SB];
   assign rd_press   = rd_data[EW-1-SB -: SB];
   assign rd_state   = rd_data[STB:1];
   assign last_issue = (CW'(issue_ff) == held_ff - 1'b1);

   // Magnitudes for the truncating signed means.
   assign t_mag      = t_sum_ff[AW-1] ? -t_sum_ff : t_sum_ff;
   assign p_mag      = p_sum_ff[AW-1] ? -p_sum_ff : p_sum_ff;
   assign s_dividend = DW'({s_sum_ff, 1'b0}) + DW'(held_ff);
   assign div_start  = (state_ff == ST_START);

   wmm_div #(.DW(DW)) u_div_temp (
      .clock (clock), .reset (reset), .start (div_start),
      .dividend (DW'(t_mag)), .divisor (DW'(held_ff)),
      .busy (t_busy), .quotient (t_quo)
   );
   wmm_div #(.DW(DW)) u_div_press (
      .clock (clock), .reset (reset), .start (div_start),
      .dividend (DW'(p_mag)), .divisor (DW'(held_ff)),
      .busy (p_busy), .quotient (p_quo)
   );
   wmm_div #(.DW(DW)) u_div_state (
      .clock (clock), .reset (reset), .start (div_start),
      .dividend (s_dividend), .divisor (DW'({held_ff, 1'b0})),
      .busy (s_busy), .quotient (s_quo)
   );

   assign t_mean   = t_sum_ff[AW-1] ? -t_quo[SB-1:0] : t_quo[SB-1:0];
   assign p_mean   = p_sum_ff[AW-1] ? -p_quo[SB-1:0] : p_quo[SB-1:0];
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in   = state_ff;
      wslot_in   = wslot_ff;
      held_in    = held_ff;
      issue_in   = issue_ff;
      issuing_in = issuing_ff;
      t_hi_in    = t_hi_ff;
      t_lo_in    = t_lo_ff;
      p_hi_in    = p_hi_ff;
      p_lo_in    = p_lo_ff;
      t_sum_in   = t_sum_ff;
      p_sum_in   = p_sum_ff;
      s_sum_in   = s_sum_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               wslot_in   = (CW'(wslot_ff) + 1'b1 >= CW'(WINDOW)) ? '0 : wslot_ff + 1'b1;
               if (held_ff < CW'(WINDOW)) begin
                  held_in = held_ff + 1'b1;
               end
               issue_in   = '0;
               issuing_in = 1'b1;
               t_hi_in    = t_hi_seed_ff;
               t_lo_in    = t_lo_seed_ff;
               p_hi_in    = p_hi_seed_ff;
               p_lo_in    = p_lo_seed_ff;
               t_sum_in   = '0;
               p_sum_in   = '0;
               s_sum_in   = '0;
               state_in   = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (issuing_ff) begin
               if (last_issue) begin
                  issuing_in = 1'b0;
               end else begin
                  issue_in = issue_ff + 1'b1;
               end
            end
            if (rd_vld_ff) begin
               // Strict compares keep the earlier best on a tie.
               if (rd_temp > t_hi_ff)  t_hi_in = rd_temp;
               if (rd_temp < t_lo_ff)  t_lo_in = rd_temp;
               if (rd_press > p_hi_ff) p_hi_in = rd_press;
               if (rd_press < p_lo_ff) p_lo_in = rd_press;
               t_sum_in = t_sum_ff + AW'(rd_temp);
               p_sum_in = p_sum_ff + AW'(rd_press);
               s_sum_in = s_sum_ff + SW'(rd_state);
               if (rd_last_ff) begin
                  state_in = ST_START;
               end
            end
         end
         ST_START: state_in = ST_DIV;
         ST_DIV: begin
            if (!t_busy && !p_busy && !s_busy) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wslot_ff     <= '0;
         held_ff      <= '0;
         issue_ff     <= '0;
         issuing_ff   <= 1'b0;
         rd_vld_ff    <= 1'b0;
         rd_last_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wslot_ff   <= wslot_in;
         held_ff    <= held_in;
         issue_ff   <= issue_in;
         issuing_ff <= issuing_in;
         rd_vld_ff  <= issuing_ff;
         rd_last_ff <= issuing_ff && last_issue;
         if (state_ff == ST_LOAD && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      t_hi_ff  <= t_hi_in;
      t_lo_ff  <= t_lo_in;
      p_hi_ff  <= p_hi_in;
      p_lo_ff  <= p_lo_in;
      t_sum_ff <= t_sum_in;
      p_sum_ff <= p_sum_in;
      s_sum_ff <= s_sum_in;
      if (accept) begin
         water_ff <= req_water_seen;
      end
      if (state_ff == ST_LOAD && out_free) begin
         rsp_highest_temp  <= t_hi_ff;
         rsp_lowest_temp   <= t_lo_ff;
         rsp_mean_temp     <= t_mean;
         rsp_highest_press <= p_hi_ff;
         rsp_lowest_press  <= p_lo_ff;
         rsp_mean_press    <= p_mean;
         rsp_mean_state    <= s_quo[STB-1:0];
         rsp_water_status  <= water_ff;
         rsp_fill_count    <= FILL_BITS'(held_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `WMM_ASSERT_NEXT(a_accept_scans, clock, reset, accept, state_ff == ST_SCAN)
   `WMM_ASSERT_ALWAYS(a_held_bound, clock, reset, held_ff <= CW'(WINDOW))
   `WMM_ASSERT_ALWAYS(a_busy_has_data, clock, reset, (state_ff == ST_IDLE) || (held_ff != '0))
   `WMM_ASSERT_ALWAYS(a_no_read_in_div, clock, reset, (state_ff != ST_DIV) || !rd_vld_ff)
endmodule

/* dv/tb_window_min_max_mean_monitor_unit.sv */
`timescale 1ns / 1ps
// Self-checking bench for the sliding-window min/max/mean monitor.
// Readings go in over the req_ channel and one window summary comes back over
// the rsp_ channel for every reading. A behavioural copy of the window, kept
// inside this bench, predicts each summary but a pinned row's. Predictions
// wait in a queue and are compared in order with every rsp_ transfer.
module tb_window_min_max_mean_monitor_unit;
   import wmm_pkg::*;

   localparam int SB       = SAMPLE_BITS_DEFAULT;
   localparam int STB      = STATE_BITS_DEFAULT;
   localparam int DEPTH    = WINDOW_DEFAULT;
   localparam int N_PHASES = 5;
   localparam int PHASE_N  = 167;
   // Settling time after the last summary; generous for a full window even with stalls.
   localparam int SETTLE   = 300;
   localparam int STUCK_LIMIT = 20000;

   typedef struct packed {
      logic signed [SB-1:0] hi_t;
      logic signed [SB-1:0] lo_t;
      logic signed [SB-1:0] mean_t;
      logic signed [SB-1:0] hi_p;
      logic signed [SB-1:0] lo_p;
      logic signed [SB-1:0] mean_p;
      logic [STB-1:0]       mean_s;
      logic                 water;
      logic [FILL_BITS-1:0] fill;
   } summary_type;

   // One row of the directed stimulus; pinned rows carry a summary typed in.
   typedef struct {
      logic signed [SB-1:0] temp;
      logic signed [SB-1:0] press;
      logic [STB-1:0]       pod;
      logic                 water;
      bit                   pinned;
      summary_type          want;
   } reading_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [SB-1:0] req_temperature = '0;
   logic signed [SB-1:0] req_pressure = '0;
   logic [STB-1:0] req_pod_state = '0;
   logic req_water_seen = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic signed [SB-1:0] rsp_highest_temp, rsp_lowest_temp, rsp_mean_temp;
   logic signed [SB-1:0] rsp_highest_press, rsp_lowest_press, rsp_mean_press;
   logic [STB-1:0] rsp_mean_state;
   logic rsp_water_status;
   logic [FILL_BITS-1:0] rsp_fill_count;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [SB-1:0] csr_wdata = '0;

   always #5 clock = ~clock;

   window_min_max_mean_monitor_unit i_dut (.*);

   // Bench copy of the window and the seed registers.
   logic signed [SB-1:0] win_temp [DEPTH];
   logic signed [SB-1:0] win_press [DEPTH];
   logic [STB-1:0]       win_pod [DEPTH];
   int                   win_slot, win_held;
   logic signed [SB-1:0] seed_t_lo, seed_t_hi, seed_p_lo, seed_p_hi;

   summary_type     pending_q [$];
   reading_row_type pin_q [$];
   int              mismatches = 0;
   int              idle_cycles = 0;
   bit              calm = 1'b0;

   function automatic summary_type window_summary(reading_row_type r);
      summary_type s;
      longint   hi_t, lo_t, hi_p, lo_p, sum_t, sum_p, sum_s;
      win_temp[win_slot]  = r.temp;
      win_press[win_slot] = r.press;
      win_pod[win_slot]   = r.pod;
      win_slot = (win_slot + 1 >= DEPTH) ? 0 : win_slot + 1;
      if (win_held < DEPTH) win_held++;
      hi_t = seed_t_hi; lo_t = seed_t_lo; hi_p = seed_p_hi; lo_p = seed_p_lo;
      sum_t = 0; sum_p = 0; sum_s = 0;
      for (int i = 0; i < win_held; i++) begin
         if (win_temp[i] > hi_t) hi_t = win_temp[i];
         if (win_temp[i] < lo_t) lo_t = win_temp[i];
         if (win_press[i] > hi_p) hi_p = win_press[i];
         if (win_press[i] < lo_p) lo_p = win_press[i];
         sum_t += win_temp[i];
         sum_p += win_press[i];
         sum_s += win_pod[i];
      end
      s.hi_t = SB'(hi_t); s.lo_t = SB'(lo_t); s.hi_p = SB'(hi_p); s.lo_p = SB'(lo_p);
      // Integer division truncates towards zero, as the block must.
      s.mean_t = SB'(sum_t / win_held);
      s.mean_p = SB'(sum_p / win_held);
      s.mean_s = STB'((2 * sum_s + win_held) / (2 * win_held));
      s.water  = r.water;
      s.fill   = FILL_BITS'(win_held);
      return s;
   endfunction

   // Shadow registers and predictions follow the transfers seen on each channel.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               REG_TEMP_LOW_SEED:   seed_t_lo = csr_wdata;
               REG_TEMP_HIGH_SEED:  seed_t_hi = csr_wdata;
               REG_PRESS_LOW_SEED:  seed_p_lo = csr_wdata;
               REG_PRESS_HIGH_SEED: seed_p_hi = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            reading_row_type r;
            summary_type     s;
            r = pin_q.pop_front();
            s = window_summary(r);
            pending_q.insert(pending_q.size(), r.pinned ? r.want : s);
         end
         if (rsp_valid && rsp_ready) begin
            summary_type got, want;
            got = '{rsp_highest_temp, rsp_lowest_temp, rsp_mean_temp,
                    rsp_highest_press, rsp_lowest_press, rsp_mean_press,
                    rsp_mean_state, rsp_water_status, rsp_fill_count};
            if (pending_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("Unexpected summary %p", got);
            end else begin
               want = pending_q.pop_front();
               if (got.hi_t !== want.hi_t || got.lo_t !== want.lo_t ||
                   got.mean_t !== want.mean_t || got.hi_p !== want.hi_p ||
                   got.lo_p !== want.lo_p || got.mean_p !== want.mean_p ||
                   got.mean_s !== want.mean_s || got.water !== want.water ||
                   got.fill !== want.fill) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Summary mismatch: expected %p, actual %p", want, got);
               end
            end
         end
      end
   end

   // The receiver stalls now and then, except during the calm stretch.
   always @(posedge clock) rsp_ready <= calm || ($urandom_range(99) >= 7);

   // Watchdog: any transfer resets the count of idle cycles.
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready) || reset) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STUCK_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Sends one reading and returns at the edge of its transfer. Valid is only
   // lowered when the sender idles, so back-to-back readings keep it high.
   task automatic send_reading(reading_row_type r);
      if (!calm && $urandom_range(99) < 7) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(8, 1)) @(posedge clock);
      end
      pin_q.insert(pin_q.size(), r);
      req_valid       <= 1'b1;
      req_temperature <= r.temp;
      req_pressure    <= r.press;
      req_pod_state   <= r.pod;
      req_water_seen  <= r.water;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Seeds are only rewritten once every summary has come back and the block
   // has had time to fall idle. Valid stays high across a run of writes and is
   // lowered by the caller once the run is over.
   task automatic write_seed(logic [CSR_INDEX_BITS-1:0] idx, logic [SB-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic reading_row_type random_reading();
      reading_row_type r;
      r = '{default: '0};
      // Most readings span the full range; some cluster near zero so that the
      // seeds and the means are exercised in the middle of the range as well.
      if ($urandom_range(99) < 80) begin
         r.temp  = SB'($urandom);
         r.press = SB'($urandom);
      end else begin
         r.temp  = SB'($signed({1'b0, 10'($urandom)}) - 512);
         r.press = SB'($signed({1'b0, 10'($urandom)}) - 512);
      end
      r.pod   = STB'($urandom);
      r.water = 1'($urandom);
      return r;
   endfunction

   reading_row_type directed [16];
   logic [SB-1:0] seed_set [N_PHASES][4];

   initial begin
      // After reset, an all-zero reading gives an all-zero summary of one entry.
      directed[0] = '{16'sd0, 16'sd0, 8'd0, 1'b0, 1'b1,
                      '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 8'd0, 1'b0, 7'd1}};
      // Extremes against the reset seeds: the low temperature seed loses to the
      // zero reading held already, and state 255 over two entries rounds up.
      directed[1] = '{16'sh7fff, -16'sh8000, 8'd255, 1'b1, 1'b1,
                      '{16'sh7fff, 16'sd0, 16'sd16383, 16'sd0, -16'sh8000,
                        -16'sd16384, 8'd128, 1'b1, 7'd2}};
      directed[2] = '{-16'sh8000, 16'sh7fff, 8'd0, 1'b0, 1'b0, '0};
      directed[3] = '{16'sd25600, 16'sd25600, 8'd1, 1'b1, 1'b0, '0};
      directed[4] = '{16'sd25600, 16'sd0, 8'd2, 1'b0, 1'b0, '0};
      directed[5] = '{-16'sd1, -16'sd1, 8'd128, 1'b1, 1'b0, '0};
      directed[6] = '{16'sd1, 16'sd1, 8'd127, 1'b0, 1'b0, '0};
      directed[7] = '{16'sh5555, 16'shaaaa, 8'h55, 1'b1, 1'b0, '0};
      directed[8] = '{16'shaaaa, 16'sh5555, 8'haa, 1'b0, 1'b0, '0};
      directed[9] = '{16'sh7fff, 16'sh7fff, 8'd255, 1'b1, 1'b0, '0};
      directed[10] = '{-16'sh8000, -16'sh8000, 8'd255, 1'b1, 1'b0, '0};
      directed[11] = '{-16'sd3, 16'sd3, 8'd3, 1'b0, 1'b0, '0};
      directed[12] = '{-16'sd256, 16'sd256, 8'd254, 1'b1, 1'b0, '0};
      directed[13] = '{16'sd0, 16'sd0, 8'd0, 1'b0, 1'b0, '0};
      directed[14] = '{16'sh0001, -16'sh0002, 8'd1, 1'b1, 1'b0, '0};
      directed[15] = '{16'sh4000, -16'sh4000, 8'd64, 1'b0, 1'b0, '0};

      // Seed settings per random phase, in register order: low temperature,
      // high temperature, low pressure, high pressure. The second phase puts
      // the seeds where no reading can beat them, the third where every
      // reading beats or equals them.
      seed_set[0] = '{16'd0, 16'd0, 16'd0, 16'd0};
      seed_set[1] = '{16'h8000, 16'h7fff, 16'h8000, 16'h7fff};
      seed_set[2] = '{16'h7fff, 16'h8000, 16'h7fff, 16'h8000};
      seed_set[3] = '{16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom)};
      seed_set[4] = '{16'd25600, 16'd0, 16'd25600, 16'd0};

      seed_t_lo = SB'(LOW_SEED_RESET); seed_t_hi = SB'(HIGH_SEED_RESET);
      seed_p_lo = SB'(LOW_SEED_RESET); seed_p_hi = SB'(HIGH_SEED_RESET);
      win_slot = 0; win_held = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed[i]) send_reading(directed[i]);

      for (int ph = 0; ph < N_PHASES; ph++) begin
         // The sender holds off here until every summary has come back.
         drain();
         for (int k = 0; k < 4; k++)
            write_seed(CSR_INDEX_BITS'(k), seed_set[ph][k]);
         // An index past the last register must leave the seeds alone.
         if (ph == 3) write_seed(CSR_INDEX_BITS'($urandom_range(255, 4)), 16'($urandom));
         csr_valid <= 1'b0;
         calm = (ph == 2);
         for (int n = 0; n < PHASE_N; n++) send_reading(random_reading());
      end

      calm = 1'b0;
      drain();
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
